>>> hdl/a2p_pkg.sv
// Shared types and fixed-point constants for the atan2 polynomial block.
package a2p_pkg;

  // Fraction bits of the internal fixed-point format.
  localparam int QF = 30;
  // Quotient bits of the ratio: values 0 up to and including 1.0.
  localparam int QB = QF + 1;
  // Width of the fold arithmetic; holds pi in the internal format plus a sign.
  localparam int FW = 34;

  // Minimax coefficients, highest order first, rounded to nearest in the internal format.
  localparam logic signed [31:0] POLY_COEF [0:6] = '{
    32'sd7744777,
    -32'sd37645046,
    32'sd87698811,
    -32'sd143609290,
    32'sd213208227,
    -32'sd357824448,
    32'sd1073741824
  };

  localparam logic signed [FW-1:0] HALF_PI_Q = 34'sd1686629713;
  localparam logic signed [FW-1:0] PI_Q      = 34'sd3373259426;

  // Octant, half-plane and sign information that follows each beat.
  typedef struct packed {
    logic y_big;
    logic x_neg;
    logic y_neg;
    logic zero;
  } a2p_side_t;

endpackage

>>> hdl/a2p_div.sv
// Pipelined restoring divider: ratio = floor(lo * 2^QF / hi), one quotient bit per stage.
module a2p_div #(
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [CW-1:0]         in_lo,
  input  logic [CW-1:0]         in_hi,
  input  a2p_pkg::a2p_side_t    in_side,
  output logic                  out_valid,
  output logic [a2p_pkg::QB-1:0] out_quo,
  output a2p_pkg::a2p_side_t    out_side
);
  import a2p_pkg::*;

  logic            v_r    [0:QB-1];
  logic [CW-1:0]   rem_r  [0:QB-1];
  logic [CW-1:0]   hi_r   [0:QB-1];
  logic [QB-1:0]   quo_r  [0:QB-1];
  a2p_side_t       side_r [0:QB-1];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [CW:0]   cur;
    logic [CW+1:0] diff;
    logic          ge;
    logic [CW-1:0] hi_in;
    logic [QB-1:0] quo_in;
    logic          v_in;
    a2p_side_t     side_in;

    // Pick this stage's partial remainder: the leading bit works on lo itself.
    if (k == 0) begin : g_first
      assign cur     = {1'b0, in_lo};
      assign hi_in   = in_hi;
      assign quo_in  = '0;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign cur     = {rem_r[k-1], 1'b0};
      assign hi_in   = hi_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign v_in    = v_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Trial subtract; a clear borrow means the quotient bit is one.
    assign diff = {1'b0, cur} - {2'b00, hi_in};
    assign ge   = ~diff[CW+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? diff[CW-1:0] : cur[CW-1:0];
      hi_r[k]   <= hi_in;
      quo_r[k]  <= {quo_in[QB-2:0], ge};
      side_r[k] <= side_in;
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_quo   = quo_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule

>>> hdl/a2p_poly.sv
// Pipelined odd polynomial: square the ratio, run Horner's rule, multiply by the ratio.
module a2p_poly (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [a2p_pkg::QB-1:0] in_t,
  input  a2p_pkg::a2p_side_t     in_side,
  output logic                   out_valid,
  output logic signed [31:0]     out_mag,
  output a2p_pkg::a2p_side_t     out_side
);
  import a2p_pkg::*;

  typedef struct packed {
    logic [QB-1:0] t;
    logic [QB-1:0] t2;
    a2p_side_t     side;
  } a2p_ctx_t;

  // Round a product to the internal format, half toward plus infinity.
  function automatic logic signed [31:0] rnd_q(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd536870912;
    return s[61:30];
  endfunction

  // Square stage.
  logic                sq_v_r;
  logic [2*QB-1:0]     sq_r;
  a2p_ctx_t            sq_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else begin
      sq_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_r     <= in_t * in_t;
    sq_ctx_r <= '{t: in_t, t2: '0, side: in_side};
  end

  // Accumulator stages (index 0 holds the leading coefficient) and multiply stages.
  logic               a_v_r   [0:6];
  logic signed [31:0] acc_r   [0:6];
  a2p_ctx_t           a_ctx_r [0:6];
  logic               m_v_r   [1:7];
  logic signed [63:0] prod_r  [1:7];
  a2p_ctx_t           m_ctx_r [1:7];

  logic [2*QB-1:0] sq_rnd;
  assign sq_rnd = sq_r + (62'd1 << (QF - 1));

  // Round the square and load the leading coefficient.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r[0] <= 1'b0;
    end else begin
      a_v_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r[0]   <= POLY_COEF[0];
    a_ctx_r[0] <= '{t: sq_ctx_r.t, t2: sq_rnd[QF+QB-1:QF], side: sq_ctx_r.side};
  end

  for (genvar i = 1; i < 8; i++) begin : g_step
    logic signed [31:0] opnd;

    // The last multiply takes the ratio; the others take its square.
    assign opnd = (i == 7) ? $signed({1'b0, a_ctx_r[i-1].t})
                           : $signed({1'b0, a_ctx_r[i-1].t2});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m_v_r[i] <= 1'b0;
      end else begin
        m_v_r[i] <= a_v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      prod_r[i]  <= acc_r[i-1] * opnd;
      m_ctx_r[i] <= a_ctx_r[i-1];
    end

    // Round and add the next coefficient.
    if (i < 7) begin : g_add
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          a_v_r[i] <= 1'b0;
        end else begin
          a_v_r[i] <= m_v_r[i];
        end
      end

      always_ff @(posedge clk) begin
        acc_r[i]   <= rnd_q(prod_r[i]) + POLY_COEF[i];
        a_ctx_r[i] <= m_ctx_r[i];
      end
    end
  end

  // Round the final product into the base angle.
  logic               o_v_r;
  logic signed [31:0] mag_r;
  a2p_side_t          o_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= m_v_r[7];
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= rnd_q(prod_r[7]);
    o_side_r <= m_ctx_r[7].side;
  end

  assign out_valid = o_v_r;
  assign out_mag   = mag_r;
  assign out_side  = o_side_r;

endmodule

>>> hdl/atan2_polynomial_top.sv
// Top level of the four-quadrant atan2 polynomial approximation.
//
//  channel  ports                                 handshake
//  input    in_x_coord, in_y_coord               start high, busy low
//  result   out_angle                             out_strobe, one cycle
//
// One beat enters per cycle; busy stays low. The pipeline has one input
// stage, 31 divider stages (one quotient bit each), 16 polynomial stages (a
// multiply and a round per Horner step), one fold stage and one output stage.
// Synchronous reset clears the valid bits only; beats in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module atan2_polynomial_top #(
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  output logic                          out_strobe,
  output logic signed [15:0]            out_angle
);
  import a2p_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int SH = QF - ANGLE_FRAC_BITS;
  localparam logic [FW-1:0] RND = FW'(1) << (SH - 1);

  assign busy = 1'b0;

  // Take magnitudes, sort them and note the octant.
  logic [CW-1:0] ax, ay;
  logic          accept;
  a2p_side_t     side_nxt;

  assign accept = start & ~busy;
  assign ax = in_x_coord[CW-1] ? (~in_x_coord + CW'(1)) : in_x_coord;
  assign ay = in_y_coord[CW-1] ? (~in_y_coord + CW'(1)) : in_y_coord;

  always_comb begin
    side_nxt.y_big = ay > ax;
    side_nxt.x_neg = in_x_coord[CW-1];
    side_nxt.y_neg = in_y_coord[CW-1];
    side_nxt.zero  = (ax == '0) && (ay == '0);
  end

  logic          in_v_r;
  logic [CW-1:0] lo_r, hi_r;
  a2p_side_t     in_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= side_nxt.y_big ? ax : ay;
    hi_r      <= side_nxt.y_big ? ay : ax;
    in_side_r <= side_nxt;
  end

  // Ratio of the smaller magnitude to the larger.
  logic          div_v;
  logic [QB-1:0] div_q;
  a2p_side_t     div_side;

  a2p_div #(.CW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_v_r),
    .in_lo    (lo_r),
    .in_hi    (hi_r),
    .in_side  (in_side_r),
    .out_valid(div_v),
    .out_quo  (div_q),
    .out_side (div_side)
  );

  // Base angle of the ratio.
  logic               poly_v;
  logic signed [31:0] poly_mag;
  a2p_side_t          poly_side;

  a2p_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (div_v),
    .in_t     (div_q),
    .in_side  (div_side),
    .out_valid(poly_v),
    .out_mag  (poly_mag),
    .out_side (poly_side)
  );

  // Fold by octant and half plane, clamp at zero.
  logic signed [FW-1:0] fold_nxt;
  logic                 fold_v_r;
  logic [FW-1:0]        fold_r;
  a2p_side_t            fold_side_r;

  always_comb begin
    fold_nxt = {{(FW-32){poly_mag[31]}}, poly_mag};
    if (poly_side.y_big) begin
      fold_nxt = HALF_PI_Q - fold_nxt;
    end
    if (poly_side.x_neg) begin
      fold_nxt = PI_Q - fold_nxt;
    end
    if (fold_nxt < 0) begin
      fold_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_v_r <= 1'b0;
    end else begin
      fold_v_r <= poly_v;
    end
  end

  always_ff @(posedge clk) begin
    fold_r      <= fold_nxt;
    fold_side_r <= poly_side;
  end

  // Round to the output format and apply the sign.
  logic [FW-1:0]      rnd_full;
  logic [15:0]        rnd16;
  logic signed [15:0] angle_nxt;
  logic               out_v_r;
  logic signed [15:0] angle_r;

  assign rnd_full = (fold_r + RND) >> SH;
  assign rnd16    = rnd_full[15:0];

  always_comb begin
    if (fold_side_r.zero) begin
      angle_nxt = '0;
    end else if (fold_side_r.y_neg) begin
      angle_nxt = $signed(16'(~rnd16 + 16'd1));
    end else begin
      angle_nxt = $signed(rnd16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= fold_v_r;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_angle  = angle_r;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the atan2 polynomial block: random and corner coordinate beats.
`timescale 1ns / 100ps

module tb;

  // Fixed-point format of the angle computation.
  localparam int     CW          = 16;
  localparam int     AFB         = 13;
  localparam int     QF          = 30;
  localparam longint Q_HALF      = 64'sd1 <<< (QF - 1);
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint ATAN_COEF [0:6] = '{
    64'sd7744777, -64'sd37645046, 64'sd87698811, -64'sd143609290,
    64'sd213208227, -64'sd357824448, 64'sd1073741824
  };
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam int RAND_BEATS  = 850;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    bit                   drain;
  } coord_beat_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic signed [CW-1:0] in_x_coord  = '0;
  logic signed [CW-1:0] in_y_coord  = '0;
  logic                 busy;
  logic                 out_strobe;
  logic signed [15:0]   out_angle;

  coord_beat_t        coord_q[$];
  logic signed [15:0] angle_q[$];
  int                 pending_cnt = 0;
  bit                 all_sent    = 1'b0;
  int                 idle_cycles = 0;
  int                 mismatches  = 0;

  atan2_polynomial_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_x_coord (in_x_coord),
    .in_y_coord (in_y_coord),
    .out_strobe (out_strobe),
    .out_angle  (out_angle)
  );

  always #2 clk = ~clk;

  // Product of two Q30 values, rounded half up to Q30.
  function automatic longint mul_round_q30(longint a, longint b);
    return (a * b + Q_HALF) >>> QF;
  endfunction

  // Expected angle for one coordinate pair.
  function automatic logic signed [15:0] atan2_angle(logic signed [CW-1:0] xc,
                                                     logic signed [CW-1:0] yc);
    longint xv, yv, ax, ay, hi, lo, ratio, ratio_sq, acc, mag, r;
    bit     y_big;
    int     i;
    xv = xc;
    yv = yc;
    ax = (xv < 0) ? -xv : xv;
    ay = (yv < 0) ? -yv : yv;
    y_big = ay > ax;
    hi = y_big ? ay : ax;
    lo = y_big ? ax : ay;
    if (hi == 0)
      return '0;
    ratio = (lo <<< QF) / hi;
    ratio_sq = mul_round_q30(ratio, ratio);
    // Horner chain in the squared ratio, then scale by the ratio
    acc = ATAN_COEF[0];
    for (i = 1; i < 7; i++)
      acc = mul_round_q30(acc, ratio_sq) + ATAN_COEF[i];
    mag = mul_round_q30(acc, ratio);
    // Fold by octant, half plane and sign
    if (y_big)
      mag = HALF_PI_Q30 - mag;
    if (xv < 0)
      mag = PI_Q30 - mag;
    if (mag < 0)
      mag = 0;
    r = (mag + (64'sd1 <<< (QF - 1 - AFB))) >>> (QF - AFB);
    if (yv < 0)
      r = -r;
    return r[15:0];
  endfunction

  function automatic void add_coord(int xv, int yv, bit drain);
    coord_beat_t b;
    b.x = xv[CW-1:0];
    b.y = yv[CW-1:0];
    b.drain = drain;
    coord_q.push_back(b);
  endfunction

  function automatic int corner_value();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return -32767;
      3: return 0;
      4: return 1;
      default: return -1;
    endcase
  endfunction

  // Driver: present queued beats in bursts with random gaps.
  always @(posedge clk) begin
    coord_beat_t nxt;
    logic        next_start;
    int          burst_left;
    int          gap_left;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else if (!start || !busy) begin
      next_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (coord_q.size() != 0) begin
        // hold a drain beat until every expected angle has come back
        if (!(coord_q[0].drain && (start || pending_cnt != 0))) begin
          nxt = coord_q.pop_front();
          in_x_coord <= nxt.x;
          in_y_coord <= nxt.y;
          next_start = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end else begin
        all_sent <= 1'b1;
      end
      start <= next_start;
    end
  end

  // Monitor: check each result beat, then record the angle of an accepted input.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n) begin
      if (out_strobe) begin
        if (angle_q.size() == 0) begin
          $error("out_angle: no result expected, got %0d", out_angle);
          mismatches++;
        end else begin
          want = angle_q.pop_front();
          if (out_angle !== want) begin
            $error("out_angle: expected %0d, got %0d", want, out_angle);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        angle_q.push_back(atan2_angle(in_x_coord, in_y_coord));
      pending_cnt <= angle_q.size();
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n && !((start && !busy) || out_strobe))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int k;
    int xv;
    int yv;
    int d;
    // Directed corners: origin, axes, extremes, diagonals, sign mixes
    add_coord(0, 0, 1'b0);
    add_coord(1, 0, 1'b0);
    add_coord(-1, 0, 1'b0);
    add_coord(-32768, 0, 1'b0);
    add_coord(32767, 0, 1'b0);
    add_coord(0, 1, 1'b0);
    add_coord(0, -1, 1'b0);
    add_coord(0, 32767, 1'b0);
    add_coord(0, -32768, 1'b0);
    add_coord(-32768, -32768, 1'b0);
    add_coord(32767, 32767, 1'b0);
    add_coord(-32768, 32767, 1'b0);
    add_coord(32767, -32768, 1'b0);
    add_coord(1, 1, 1'b0);
    add_coord(-1, -1, 1'b0);
    add_coord(-1, 1, 1'b0);
    add_coord(5, -3, 1'b0);
    add_coord(-3, 5, 1'b0);
    add_coord(32767, -1, 1'b0);
    add_coord(-32768, 1, 1'b0);
    add_coord(1, -32768, 1'b0);
    add_coord(-32767, -1, 1'b0);
    // Random pairs, shaped toward small ratios, axes and the diagonal
    for (k = 0; k < RAND_BEATS; k++) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          xv = $urandom;
          yv = $urandom;
        end
        2: begin
          xv = $urandom_range(0, 16) - 8;
          yv = $urandom_range(0, 16) - 8;
        end
        3: begin
          xv = $urandom;
          yv = $urandom_range(0, 8) - 4;
          if ($urandom_range(0, 1)) begin
            d = xv;
            xv = yv;
            yv = d;
          end
        end
        4: begin
          xv = $signed(16'($urandom));
          d = $urandom_range(0, 6) - 3;
          yv = $urandom_range(0, 1) ? xv + d : -xv + d;
        end
        default: begin
          xv = corner_value();
          yv = corner_value();
        end
      endcase
      add_coord(xv, yv, (k % 250) == 0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (!(all_sent && pending_cnt == 0))
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
